// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LZW_ASSERT(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("assertion failed");
`define LZW_ASSERT_NEXT(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define LZW_ASSERT(lbl, clk, rstn, cond)
`define LZW_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif

`endif

// File: hw/rtl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW compressor package
// Sizes, state encoding and the dictionary hash.
// ----------------------------------------------------------------------------
`default_nettype none

package lzw_pkg;

	localparam int DICT_ENTRIES = 4096;
	localparam int CODE_START   = 256;
	localparam int WIDTH_START  = 9;
	localparam int STORE_DEPTH  = 4096;
	localparam int DICT_LIMIT   = (DICT_ENTRIES > STORE_DEPTH) ? STORE_DEPTH :
		((DICT_ENTRIES < CODE_START) ? CODE_START : DICT_ENTRIES);

	localparam int CODE_W     = 12;
	localparam int KEY_W      = CODE_W + 8;
	localparam int NFC_W      = CODE_W + 1;
	localparam int WID_W      = 4;
	localparam int HASH_AW    = CODE_W + 1;
	localparam int HASH_DEPTH = 2 * STORE_DEPTH;
	localparam int HENT_W     = KEY_W + CODE_W;
	localparam int ACC_W      = 7 + CODE_W;
	localparam int CNT_W      = 5;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE_A,
		ST_PROBE_B,
		ST_PUT_FINAL,
		ST_DRAIN
	} state_t;

	function automatic logic [HASH_AW-1:0] hash_idx(input logic [CODE_W-1:0] p,
		input logic [7:0] b);
		hash_idx = {1'b0, p} ^ {b, 5'b0} ^ {5'b0, b};
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lzw_compressor.sv
// Hit or miss is decided in ST_PROBE_B, after a hash RAM read and then a code RAM
// read; each extra hash probe (linear probing in the 8192-slot hash RAM) repeats
// ST_PROBE_A and ST_PROBE_B. A miss then passes through ST_DRAIN, which sends each
// packed output byte; a last byte adds a flush pass. Bytes are taken one at a time.
// Reset: asynchronous; clears control and packing state, then an ST_CLEAR pass
// zeroes all 8192 hash RAM slots before the first input transfer.
// ----------------------------------------------------------------------------
// LZW compressor
// Variable-width LZW with a hashed dictionary and LSB-first byte packing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lzw_compressor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] out_byte,
	output logic            last
);

	lzw_pkg::state_t state_q, state_d;

	logic [lzw_pkg::CODE_W-1:0]  prefix_q;
	logic                        pvalid_q;
	logic [lzw_pkg::NFC_W-1:0]   nfc_q;
	logic [lzw_pkg::WID_W-1:0]   width_q;
	logic [lzw_pkg::ACC_W-1:0]   acc_q;
	logic [lzw_pkg::CNT_W-1:0]   cnt_q;
	logic                        final_q;
	logic [7:0]                  byte_q;
	logic                        lastin_q;
	logic [lzw_pkg::HASH_AW-1:0] slot_q;
	logic [lzw_pkg::HASH_AW-1:0] clr_q;
	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        out_last_q;

	// hash RAM: {key, code}; code RAM: slot that owns each code
	logic                        h_we;
	logic [lzw_pkg::HASH_AW-1:0] h_waddr, h_raddr;
	logic [lzw_pkg::HENT_W-1:0]  h_wdata, h_rdata;
	logic                        d_we;
	logic [lzw_pkg::CODE_W-1:0]  d_waddr, d_raddr;
	logic [lzw_pkg::HASH_AW-1:0] d_wdata, d_rdata;

	logic                        in_xfer, out_free, out_load;
	logic [lzw_pkg::KEY_W-1:0]   key_cur, h_key;
	logic [lzw_pkg::CODE_W-1:0]  h_code, put_code;
	logic                        occ, hit;
	logic [lzw_pkg::NFC_W-1:0]   mask13, nfc_inc;
	logic [lzw_pkg::ACC_W-1:0]   put_acc;
	logic [lzw_pkg::CNT_W-1:0]   put_cnt;
	logic                        can_add;

	lzw_ram #(.WIDTH(lzw_pkg::HENT_W), .DEPTH(lzw_pkg::HASH_DEPTH)) u_hash_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	lzw_ram #(.WIDTH(lzw_pkg::HASH_AW), .DEPTH(lzw_pkg::STORE_DEPTH)) u_code_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == lzw_pkg::ST_DRAIN) && out_free &&
		((cnt_q >= lzw_pkg::CNT_W'(8)) || (final_q && cnt_q != '0));
	assign key_cur  = {prefix_q, byte_q};
	assign h_key    = h_rdata[lzw_pkg::HENT_W-1:lzw_pkg::CODE_W];
	assign h_code   = h_rdata[lzw_pkg::CODE_W-1:0];

	// a slot is live only if it holds a current code and that code points back to it
	assign occ = ({1'b0, h_code} >= lzw_pkg::NFC_W'(lzw_pkg::CODE_START)) &&
		({1'b0, h_code} < nfc_q) && (d_rdata == slot_q);
	assign hit = occ && (h_key == key_cur);

	assign put_code = (state_q == lzw_pkg::ST_PUT_FINAL) ? prefix_q : prefix_q;
	assign mask13   = (lzw_pkg::NFC_W'(1) << width_q) - lzw_pkg::NFC_W'(1);
	assign put_acc  = acc_q |
		(lzw_pkg::ACC_W'(put_code & mask13[lzw_pkg::CODE_W-1:0]) << cnt_q);
	assign put_cnt  = cnt_q + lzw_pkg::CNT_W'(width_q);
	assign nfc_inc  = nfc_q + lzw_pkg::NFC_W'(1);
	assign can_add  = nfc_q < lzw_pkg::NFC_W'(lzw_pkg::DICT_LIMIT);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzw_pkg::ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = lzw_pkg::ST_IDLE;
				end
			end
			lzw_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (!pvalid_q) begin
						state_d = last_byte ? lzw_pkg::ST_PUT_FINAL : lzw_pkg::ST_IDLE;
					end else begin
						state_d = lzw_pkg::ST_PROBE_A;
					end
				end
			end
			lzw_pkg::ST_PROBE_A: state_d = lzw_pkg::ST_PROBE_B;
			lzw_pkg::ST_PROBE_B: begin
				if (hit) begin
					state_d = lastin_q ? lzw_pkg::ST_PUT_FINAL : lzw_pkg::ST_IDLE;
				end else if (occ) begin
					state_d = lzw_pkg::ST_PROBE_A;
				end else begin
					state_d = lzw_pkg::ST_DRAIN;
				end
			end
			lzw_pkg::ST_PUT_FINAL: state_d = lzw_pkg::ST_DRAIN;
			lzw_pkg::ST_DRAIN: begin
				if (cnt_q < lzw_pkg::CNT_W'(8)) begin
					if (!final_q) begin
						state_d = lastin_q ? lzw_pkg::ST_PUT_FINAL : lzw_pkg::ST_IDLE;
					end else if (cnt_q == '0 || out_free) begin
						state_d = lzw_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = lzw_pkg::ST_IDLE;
		endcase
	end

	// handshake and memory controls
	always_comb begin
		in_ready = 1'b0;
		h_raddr  = slot_q;
		h_we     = 1'b0;
		h_waddr  = slot_q;
		h_wdata  = {key_cur, nfc_q[lzw_pkg::CODE_W-1:0]};
		d_raddr  = h_code;
		d_we     = 1'b0;
		d_waddr  = nfc_q[lzw_pkg::CODE_W-1:0];
		d_wdata  = slot_q;
		case (state_q)
			lzw_pkg::ST_CLEAR: begin
				// code 0 in a slot reads as empty
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = '0;
			end
			lzw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				h_raddr  = lzw_pkg::hash_idx(prefix_q, data_byte);
			end
			lzw_pkg::ST_PROBE_B: begin
				if (!hit && occ) begin
					h_raddr = slot_q + lzw_pkg::HASH_AW'(1);
				end else if (!hit && can_add) begin
					h_we = 1'b1;
					d_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzw_pkg::ST_CLEAR;
			clr_q       <= '0;
			prefix_q    <= '0;
			pvalid_q    <= 1'b0;
			nfc_q       <= lzw_pkg::NFC_W'(lzw_pkg::CODE_START);
			width_q     <= lzw_pkg::WID_W'(lzw_pkg::WIDTH_START);
			acc_q       <= '0;
			cnt_q       <= '0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lzw_pkg::ST_CLEAR: begin
					clr_q <= clr_q + lzw_pkg::HASH_AW'(1);
				end
				lzw_pkg::ST_IDLE: begin
					if (in_xfer && !pvalid_q) begin
						prefix_q <= lzw_pkg::CODE_W'(data_byte);
						pvalid_q <= 1'b1;
					end
				end
				lzw_pkg::ST_PROBE_B: begin
					if (hit) begin
						prefix_q <= h_code;
					end else if (!occ) begin
						acc_q    <= put_acc;
						cnt_q    <= put_cnt;
						final_q  <= 1'b0;
						prefix_q <= lzw_pkg::CODE_W'(byte_q);
						if (can_add) begin
							nfc_q <= nfc_inc;
							if (nfc_inc > (lzw_pkg::NFC_W'(1) << width_q)) begin
								width_q <= width_q + lzw_pkg::WID_W'(1);
							end
						end
					end
				end
				lzw_pkg::ST_PUT_FINAL: begin
					acc_q   <= put_acc;
					cnt_q   <= put_cnt;
					final_q <= 1'b1;
				end
				lzw_pkg::ST_DRAIN: begin
					if (cnt_q >= lzw_pkg::CNT_W'(8)) begin
						if (out_free) begin
							acc_q <= acc_q >> 8;
							cnt_q <= cnt_q - lzw_pkg::CNT_W'(8);
						end
					end else if (final_q && (cnt_q == '0 || out_free)) begin
						// flush the partial byte and restart the dictionary
						acc_q    <= '0;
						cnt_q    <= '0;
						prefix_q <= '0;
						pvalid_q <= 1'b0;
						nfc_q    <= lzw_pkg::NFC_W'(lzw_pkg::CODE_START);
						width_q  <= lzw_pkg::WID_W'(lzw_pkg::WIDTH_START);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q   <= data_byte;
			lastin_q <= last_byte;
			slot_q   <= lzw_pkg::hash_idx(prefix_q, data_byte);
		end else if (state_q == lzw_pkg::ST_PROBE_B && !hit && occ) begin
			slot_q <= slot_q + lzw_pkg::HASH_AW'(1);
		end
		if (state_q == lzw_pkg::ST_DRAIN && out_free) begin
			if (cnt_q >= lzw_pkg::CNT_W'(8)) begin
				out_byte_q <= acc_q[7:0];
				out_last_q <= final_q && (cnt_q == lzw_pkg::CNT_W'(8));
			end else if (final_q && cnt_q != '0) begin
				out_byte_q <= acc_q[7:0];
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;

	`LZW_ASSERT(a_nfc_range, clk, arst_n, nfc_q >= lzw_pkg::NFC_W'(lzw_pkg::CODE_START) && nfc_q <= lzw_pkg::NFC_W'(lzw_pkg::DICT_LIMIT))
	`LZW_ASSERT(a_width_range, clk, arst_n, width_q >= 4'd9 && width_q <= 4'd12)
	`LZW_ASSERT(a_idle_pending, clk, arst_n, state_q != lzw_pkg::ST_IDLE || cnt_q < 5'd8)
	`LZW_ASSERT_NEXT(a_final_drain, clk, arst_n, state_q == lzw_pkg::ST_PUT_FINAL, state_q == lzw_pkg::ST_DRAIN && final_q)

endmodule

`default_nettype wire

// File: hw/rtl/lzw_ram.sv
// ----------------------------------------------------------------------------
// LZW generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: dv/lzw_compressor_test.sv
// ----------------------------------------------------------------------------
// LZW compressor testbench
// Feeds byte messages through valid/ready with random gaps and output stalls.
// A behavioral LZW packer computes the expected byte stream; every output
// transfer is compared in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_compressor_test;

	localparam int HALF_PERIOD = 2;
	localparam int IDLE_LIMIT  = 40000;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} out_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last;

	lzw_compressor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// predictor state
	logic [19:0] dict_keys [lzw_pkg::CODE_START:lzw_pkg::STORE_DEPTH-1];
	logic [11:0] cur_prefix;
	logic        have_prefix;
	int          free_code;
	int          code_width;
	logic [6:0]  held_bits;
	int          held_count;

	in_item_t  send_q [$];
	out_item_t packed_q [$];
	int        errors = 0;
	int        bytes_in = 0;
	int        bytes_out = 0;
	int        messages = 0;
	bit        rx_hold = 1'b0;
	bit        tx_pause = 1'b0;

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h (out #%0d)", what, got, want, bytes_out);
	endtask

	task automatic clear_dict();
		cur_prefix  = '0;
		have_prefix = 1'b0;
		free_code   = lzw_pkg::CODE_START;
		code_width  = lzw_pkg::WIDTH_START;
	endtask

	task automatic pack_code(input logic [11:0] code);
		logic [31:0] acc;
		int nb;
		acc = {25'd0, held_bits} | ((32'(code) & ((32'd1 << code_width) - 1)) << held_count);
		nb = held_count + code_width;
		while (nb >= 8) begin
			packed_q.push_back('{acc[7:0], 1'b0});
			acc = acc >> 8;
			nb -= 8;
		end
		held_bits  = acc[6:0];
		held_count = nb;
	endtask

	task automatic compress_byte(input in_item_t it);
		int hit;
		int base;
		base = packed_q.size();
		if (!have_prefix) begin
			cur_prefix  = 12'(it.data);
			have_prefix = 1'b1;
		end else begin
			hit = -1;
			for (int c = lzw_pkg::CODE_START; c < free_code; c++)
				if (hit < 0 && dict_keys[c] == {cur_prefix, it.data})
					hit = c;
			if (hit >= 0) begin
				cur_prefix = 12'(hit);
			end else begin
				pack_code(cur_prefix);
				if (free_code < lzw_pkg::DICT_LIMIT) begin
					dict_keys[free_code] = {cur_prefix, it.data};
					free_code++;
					if (free_code > (1 << code_width))
						code_width++;
				end
				cur_prefix = 12'(it.data);
			end
		end
		if (it.fin) begin
			pack_code(cur_prefix);
			if (held_count > 0)
				packed_q.push_back('{8'(held_bits), 1'b0});
			if (packed_q.size() > base)
				packed_q[packed_q.size()-1].fin = 1'b1;
			held_bits  = '0;
			held_count = 0;
			clear_dict();
			messages++;
		end
	endtask

	// driver
	int tx_gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			compress_byte('{data_byte, last_byte});
			bytes_in++;
		end
		if (in_valid && !in_ready) begin
			// hold payload
		end else if (tx_gap > 0) begin
			in_valid <= 1'b0;
			tx_gap   <= tx_gap - 1;
		end else if (send_q.size() > 0 && !tx_pause && arst_n) begin
			in_valid  <= 1'b1;
			data_byte <= send_q[0].data;
			last_byte <= send_q[0].fin;
			void'(send_q.pop_front());
			tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor and receiver stalls
	int rx_gap = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			bytes_out++;
			if (packed_q.size() == 0) begin
				report("unexpected byte", out_byte, 8'h00);
			end else begin
				if (out_byte !== packed_q[0].data)
					report("out_byte", out_byte, packed_q[0].data);
				if (last !== packed_q[0].fin)
					report("last", 8'(last), 8'(packed_q[0].fin));
				void'(packed_q.pop_front());
			end
		end
		if (rx_hold || !arst_n) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			out_ready <= (rx_gap == 0);
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= (rx_gap == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet);
			$display("FAIL lzw_compressor");
			$finish;
		end
	end

	task automatic queue_msg(input int len, input int alpha);
		in_item_t it;
		for (int i = 0; i < len; i++) begin
			it.data = (alpha >= 256) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, alpha));
			it.fin  = (i == len - 1);
			send_q.push_back(it);
		end
	endtask

	initial begin
		in_item_t it;
		held_bits  = '0;
		held_count = 0;
		clear_dict();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single-byte messages at the extremes, repeats, alternating bit patterns
		send_q.push_back('{8'h00, 1'b1});
		send_q.push_back('{8'hFF, 1'b1});
		send_q.push_back('{8'h00, 1'b0});
		send_q.push_back('{8'hFF, 1'b1});
		for (int i = 0; i < 8; i++) send_q.push_back('{8'h41, 1'b0});
		send_q.push_back('{8'h41, 1'b1});
		send_q.push_back('{8'h55, 1'b0});
		send_q.push_back('{8'hAA, 1'b0});
		send_q.push_back('{8'h55, 1'b0});
		send_q.push_back('{8'hAA, 1'b0});
		send_q.push_back('{8'h55, 1'b1});
		wait (send_q.size() == 0);

		// sender pause until every expected byte has drained
		tx_pause = 1'b1;
		wait (!in_valid && packed_q.size() == 0);
		repeat (30) @(posedge clk);
		tx_pause = 1'b0;

		// receiver holds off long while inputs keep coming
		rx_hold = 1'b1;
		queue_msg(20, 3);
		repeat (400) @(posedge clk);
		rx_hold = 1'b0;
		wait (send_q.size() == 0);

		// 257 distinct pairs in one message cross the 9 to 10 bit width change
		for (int i = 0; i < 258; i++) begin
			it.data = (i < 256) ? 8'(i) : 8'(2 * (i - 256));
			it.fin  = (i == 257);
			send_q.push_back(it);
		end
		wait (send_q.size() == 0 && !in_valid);
		wait (packed_q.size() == 0);
		repeat (50) @(posedge clk);

		$display("covered %0d input bytes in %0d messages, %0d packed bytes checked",
			bytes_in, messages, bytes_out);
		if (errors == 0)
			$display("PASS lzw_compressor");
		else
			$display("FAIL lzw_compressor");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/lzw_pkg.sv
hw/rtl/lzw_ram.sv
hw/rtl/lzw_compressor.sv
dv/lzw_compressor_test.sv
